FILE: sv/odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types and constants of the two-wheel odometry update unit.
// ----------------------------------------------------------------------------
package odo_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int ANGLE_DROP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
	localparam logic [15:0] ANGLE_MASK = 16'(17'h10000 - (17'd1 << ANGLE_DROP));

	localparam int MUL_A_W = 38;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [2:0] REG_MOUNT_A = 3'd0;
	localparam logic [2:0] REG_MOUNT_B = 3'd1;
	localparam logic [2:0] REG_OFF_A   = 3'd2;
	localparam logic [2:0] REG_OFF_B   = 3'd3;
	localparam logic [2:0] REG_INV_SIN = 3'd4;
	localparam logic [2:0] REG_START_X = 3'd5;
	localparam logic [2:0] REG_START_Y = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [15:0]        mount_a;
		logic [15:0]        mount_b;
		logic signed [31:0] off_a;
		logic signed [31:0] off_b;
		logic signed [15:0] inv_sin;
		logic signed [47:0] start_x;
		logic signed [47:0] start_y;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        restart;
		logic [15:0] heading;
		logic signed [31:0] dist_a;
		logic signed [31:0] dist_b;
	} item_t;

endpackage
`default_nettype wire

FILE: sv/odo_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module odo_mul import odo_pkg::*; (
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]       prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule
`default_nettype wire

FILE: sv/odo_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odo_core
// Step sequencer around the shared multiplier: turn correction, four sine
// evaluations, rotation, scaling and saturating accumulation.
// ----------------------------------------------------------------------------
module odo_core import odo_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	input  wire item_t         item,
	output logic               in_ready,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic signed [47:0] acc_x_q,
	output logic signed [47:0] acc_y_q
);

	localparam logic [4:0] STEP_CORR_A = 5'd0;
	localparam logic [4:0] STEP_CORR_B = 5'd1;
	localparam logic [4:0] STEP_SIN_0  = 5'd2;
	localparam logic [4:0] STEP_SIN_E  = 5'd17;
	localparam logic [4:0] STEP_STORE0 = 5'd6;
	localparam logic [4:0] STEP_PROJ0  = 5'd18;
	localparam logic [4:0] STEP_PROJ1  = 5'd19;
	localparam logic [4:0] STEP_PROJ2  = 5'd20;
	localparam logic [4:0] STEP_PROJ3  = 5'd21;
	localparam logic [4:0] STEP_SCL_X  = 5'd22;
	localparam logic [4:0] STEP_SCL_Y  = 5'd23;
	localparam logic [4:0] STEP_LAST   = 5'd24;

	localparam logic signed [49:0] POS_MAX = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] POS_MIN = -50'sh0_8000_0000_0000;

	state_t state_q, state_n;
	logic [4:0] step_q;

	logic [15:0]        hd_q, last_h_q;
	logic signed [31:0] wa_q, wb_q, last_a_q, last_b_q;
	logic signed [15:0] dh_q;
	logic signed [33:0] da_q, db_q;
	logic [14:0]        z2_q;
	logic               neg_q;
	logic signed [16:0] sin_q [4];
	logic signed [PROD_W-1:0] psum_q;
	logic signed [34:0] sx_q, sy_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;

	logic [4:0]  sidx;
	logic [1:0]  sj, sm;
	logic [15:0] ang;
	logic [14:0] zv;
	logic signed [MUL_B_W-1:0] t14;
	logic signed [PROD_W-1:0]  corr_w, sx_w, sy_w, dx_w, dy_w;
	logic signed [33:0] corr;
	logic signed [16:0] r17;
	logic signed [49:0] sum_x, sum_y;
	logic in_fire, sine_step, store_step;

	odo_mul u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (item.valid) state_n = item.restart ? ST_WRITE : ST_RUN;
			ST_RUN:   if (step_q == STEP_LAST) state_n = ST_WRITE;
			ST_WRITE: if (res_ready) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_WRITE);
	end

	assign in_fire    = in_ready && item.valid;
	assign sidx       = step_q - STEP_SIN_0;
	assign sj         = sidx[3:2];
	assign sm         = sidx[1:0];
	assign sine_step  = (step_q inside {[STEP_SIN_0:STEP_SIN_E]});
	assign store_step = (step_q inside {[STEP_STORE0:STEP_PROJ0]}) && (sm == 2'd0);

	always_comb begin
		ang = hd_q + (((sj == 2'd0) || (sj == 2'd3)) ? cfg.mount_b : cfg.mount_a)
			+ (sj[1] ? 16'h4000 : 16'h0000);
		ang = ang & ANGLE_MASK;
		zv  = ang[14] ? (15'h4000 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
	end

	assign t14    = MUL_B_W'(prod_q >>> 14);
	assign r17    = 17'(prod_q >>> 14);
	assign corr_w = (prod_q + PROD_W'(32768)) >>> 16;
	assign corr   = 34'(corr_w);
	assign sx_w   = (psum_q - prod_q + PROD_W'(16384)) >>> 15;
	assign sy_w   = (prod_q - psum_q + PROD_W'(16384)) >>> 15;
	assign dx_w   = (prod_q + PROD_W'(2048)) >>> 12;
	assign dy_w   = dx_w;
	assign sum_x  = 50'(acc_x_q) + 50'(dx_w);
	assign sum_y  = 50'(acc_y_q) + 50'(dy_w);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (sine_step) begin
			case (sm)
				2'd0: begin mul_a = MUL_A_W'(zv); mul_b = MUL_B_W'(zv); end
				2'd1: begin mul_a = MUL_A_W'(t14); mul_b = MUL_B_W'(2285); end
				2'd2: begin mul_a = MUL_A_W'(z2_q); mul_b = MUL_B_W'(20954) - t14; end
				default: begin mul_a = MUL_A_W'(zv); mul_b = MUL_B_W'(51437) - t14; end
			endcase
		end else begin
			case (step_q)
				STEP_CORR_A: begin mul_a = MUL_A_W'(cfg.off_a); mul_b = MUL_B_W'(dh_q); end
				STEP_CORR_B: begin mul_a = MUL_A_W'(cfg.off_b); mul_b = MUL_B_W'(dh_q); end
				STEP_PROJ0: begin mul_a = MUL_A_W'(da_q); mul_b = MUL_B_W'(sin_q[0]); end
				STEP_PROJ1: begin mul_a = MUL_A_W'(db_q); mul_b = MUL_B_W'(sin_q[1]); end
				STEP_PROJ2: begin mul_a = MUL_A_W'(da_q); mul_b = MUL_B_W'(sin_q[3]); end
				STEP_PROJ3: begin mul_a = MUL_A_W'(db_q); mul_b = MUL_B_W'(sin_q[2]); end
				STEP_SCL_X: begin mul_a = MUL_A_W'(sx_q); mul_b = MUL_B_W'(cfg.inv_sin); end
				STEP_SCL_Y: begin mul_a = MUL_A_W'(sy_q); mul_b = MUL_B_W'(cfg.inv_sin); end
				default:    begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			last_h_q <= '0;
			last_a_q <= '0;
			last_b_q <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_RUN) step_q <= step_q + 5'd1;
			else step_q <= '0;
			if (in_fire && item.restart) begin
				acc_x_q  <= cfg.start_x;
				acc_y_q  <= cfg.start_y;
				last_a_q <= '0;
				last_b_q <= '0;
			end
			if (state_q == ST_RUN) begin
				if (step_q == STEP_SCL_Y) begin
					if (sum_x > POS_MAX) acc_x_q <= 48'(POS_MAX);
					else if (sum_x < POS_MIN) acc_x_q <= 48'(POS_MIN);
					else acc_x_q <= 48'(sum_x);
				end
				if (step_q == STEP_LAST) begin
					if (sum_y > POS_MAX) acc_y_q <= 48'(POS_MAX);
					else if (sum_y < POS_MIN) acc_y_q <= 48'(POS_MIN);
					else acc_y_q <= 48'(sum_y);
					last_h_q <= hd_q;
					last_a_q <= wa_q;
					last_b_q <= wb_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hd_q <= item.heading;
			wa_q <= item.dist_a;
			wb_q <= item.dist_b;
			dh_q <= item.heading - last_h_q;
		end
		if (state_q == ST_RUN) begin
			if (step_q == STEP_CORR_B) da_q <= 34'(wa_q) - 34'(last_a_q) - corr;
			if (step_q == STEP_SIN_0) db_q <= 34'(wb_q) - 34'(last_b_q) - corr;
			if (sine_step && sm == 2'd0) neg_q <= ang[15];
			if (sine_step && sm == 2'd1) z2_q <= 15'(t14);
			if (store_step) sin_q[sj - 2'd1] <= neg_q ? -r17 : r17;
			if (step_q == STEP_PROJ1 || step_q == STEP_PROJ3) psum_q <= prod_q;
			if (step_q == STEP_PROJ2) sx_q <= 35'(sx_w);
			if (step_q == STEP_SCL_X) sy_q <= 35'(sy_w);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == STEP_LAST) |=> (state_q == ST_WRITE))
		else $error("sequence did not end in write");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= STEP_LAST))
		else $error("step counter overran");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> ($stable(acc_x_q) && $stable(acc_y_q)))
		else $error("position changed while result held");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !in_ready)
		else $error("input taken during sequence");

endmodule
`default_nettype wire

FILE: sv/two_wheel_odometry_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_wheel_odometry_update_unit
// Dead-reckoning position tracker from gyro heading and two measuring wheels.
//
// channel   dir   payload
// s_axis    in    tdata heading/wheel_a/wheel_b, tuser req_type
// m_axis    out   tdata pos_x/pos_y
// cfg       in    we, index, data (write only)
//
// A sample is taken, runs 25 steps through the shared multiplier (turn
// corrections, four sine polynomials, rotation, scaling), and its position
// goes to the output register. A restart loads the start position instead.
// Reset clears all control state; positions reset to zero.
// A stalled output holds the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module two_wheel_odometry_update_unit import odo_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // heading, wheel_a_distance, wheel_b_distance
	input  wire logic [0:0]  s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [95:0]      m_axis_tdata,  // pos_x, pos_y
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);

	cfg_t  cfg_q;
	item_t item;
	logic  in_ready, res_valid, res_ready;
	logic signed [47:0] acc_x, acc_y;
	logic out_valid_q;
	logic [95:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mount_a <= 16'd0;
			cfg_q.mount_b <= 16'd16384;
			cfg_q.off_a   <= '0;
			cfg_q.off_b   <= '0;
			cfg_q.inv_sin <= 16'sd4096;
			cfg_q.start_x <= '0;
			cfg_q.start_y <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOUNT_A: cfg_q.mount_a <= cfg_data[15:0];
				REG_MOUNT_B: cfg_q.mount_b <= cfg_data[15:0];
				REG_OFF_A:   cfg_q.off_a   <= cfg_data[31:0];
				REG_OFF_B:   cfg_q.off_b   <= cfg_data[31:0];
				REG_INV_SIN: cfg_q.inv_sin <= cfg_data[15:0];
				REG_START_X: cfg_q.start_x <= cfg_data;
				REG_START_Y: cfg_q.start_y <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		item.valid   = s_axis_tvalid;
		item.restart = s_axis_tuser[0];
		item.heading = s_axis_tdata[15:0];
		item.dist_a  = s_axis_tdata[47:16];
		item.dist_b  = s_axis_tdata[79:48];
	end

	odo_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item     (item),
		.in_ready (in_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.acc_x_q  (acc_x),
		.acc_y_q  (acc_y)
	);

	assign s_axis_tready = in_ready;
	assign res_ready     = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_data_q <= {acc_y, acc_x};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
